// File: rtl/sbe_pkg.sv
// Package for the sparse bitset engine: request codes, sequencer states,
// store command and read structs, and sizing helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbe_pkg;

    localparam int MAX_WORDS = 64;
    localparam int WORD_W    = 64;
    localparam int SLOT_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int BITS_W    = 13;

    typedef enum logic [2:0] {
        REQ_INIT      = 3'd0,
        REQ_CLR_MASK  = 3'd1,
        REQ_INV_MASK  = 3'd2,
        REQ_OR_MASK   = 3'd3,
        REQ_STAGE     = 3'd4,
        REQ_INTERSECT = 3'd5,
        REQ_QUERY     = 3'd6
    } req_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_STAGE, S_ORD, S_SLOT, S_EXEC, S_LAST, S_SWAP, S_SWAP2, S_DONE
    } state_t;

    // Write side of the store, one command per cycle
    typedef struct packed {
        logic              clear;
        logic [SLOT_W-1:0] wr_slot;
        logic              set_we;
        logic              mask_we;
        logic              query_we;
        logic [WORD_W-1:0] wdata;
        logic              order_we;
        logic [SLOT_W-1:0] order_wpos;
        logic [SLOT_W-1:0] order_wdata;
    } store_cmd_t;

    // Registered read data of the store
    typedef struct packed {
        logic [WORD_W-1:0] set_q;
        logic [WORD_W-1:0] mask_q;
        logic [WORD_W-1:0] query_q;
        logic [SLOT_W-1:0] order_q;
    } store_rd_t;

    // Words in use: ceil(bits/64), saturated at the store depth
    function automatic logic [CNT_W-1:0] words_in_use(input logic [BITS_W-1:0] bits);
        logic [BITS_W:0] n;
        n = ({1'b0, bits} + (BITS_W+1)'(WORD_W - 1)) >> $clog2(WORD_W);
        if (n > (BITS_W+1)'(MAX_WORDS)) begin
            return CNT_W'(MAX_WORDS);
        end
        return n[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// File: rtl/sbe_store.sv
// Word, mask, query and live-order memories of the sparse bitset engine.
// Depends on sbe_pkg. Valid bits stand in for the init values of set, mask, order.
`timescale 1ns / 1ps
`default_nettype none

module sbe_store import sbe_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire store_cmd_t        cmd,
    input  wire logic [SLOT_W-1:0] rd_slot,
    input  wire logic [SLOT_W-1:0] rd_pos,
    output store_rd_t              rd
);

    logic [WORD_W-1:0] set_mem   [MAX_WORDS];
    logic [WORD_W-1:0] mask_mem  [MAX_WORDS];
    logic [WORD_W-1:0] query_mem [MAX_WORDS];
    logic [SLOT_W-1:0] order_mem [MAX_WORDS];

    logic [MAX_WORDS-1:0] set_vld_reg;
    logic [MAX_WORDS-1:0] mask_vld_reg;
    logic [MAX_WORDS-1:0] order_vld_reg;

    logic [WORD_W-1:0] set_raw_reg, mask_raw_reg, query_raw_reg;
    logic [SLOT_W-1:0] order_raw_reg, pos_reg;
    logic              set_v_reg, mask_v_reg, order_v_reg;

    // Track written entries; init drops them all back to their start values
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            set_vld_reg   <= '0;
            mask_vld_reg  <= '0;
            order_vld_reg <= '0;
        end else begin
            if (cmd.set_we)   set_vld_reg[cmd.wr_slot]      <= 1'b1;
            if (cmd.mask_we)  mask_vld_reg[cmd.wr_slot]     <= 1'b1;
            if (cmd.order_we) order_vld_reg[cmd.order_wpos] <= 1'b1;
        end
    end

    // Write and read the memories, read data registered
    always_ff @(posedge aclk) begin
        if (cmd.set_we)   set_mem[cmd.wr_slot]      <= cmd.wdata;
        if (cmd.mask_we)  mask_mem[cmd.wr_slot]     <= cmd.wdata;
        if (cmd.query_we) query_mem[cmd.wr_slot]    <= cmd.wdata;
        if (cmd.order_we) order_mem[cmd.order_wpos] <= cmd.order_wdata;
        set_raw_reg   <= set_mem[rd_slot];
        mask_raw_reg  <= mask_mem[rd_slot];
        query_raw_reg <= query_mem[rd_slot];
        order_raw_reg <= order_mem[rd_pos];
        set_v_reg     <= set_vld_reg[rd_slot];
        mask_v_reg    <= mask_vld_reg[rd_slot];
        order_v_reg   <= order_vld_reg[rd_pos];
        pos_reg       <= rd_pos;
    end

    // Substitute start values for entries not written since init
    always_comb begin
        rd.set_q   = set_v_reg   ? set_raw_reg   : '1;
        rd.mask_q  = mask_v_reg  ? mask_raw_reg  : '0;
        rd.query_q = query_raw_reg;
        rd.order_q = order_v_reg ? order_raw_reg : pos_reg;
    end

endmodule

`default_nettype wire

// File: rtl/sparse_bitset_engine.sv
// Sparse bitset engine: live-list sequencer over a synchronous word store.
// Init, stage: own state then S_DONE; unknown: S_DONE; OR: S_SLOT, S_EXEC. Clear,
// invert, query, intersect walk the live list via S_ORD, S_SLOT, S_EXEC (a query
// ends at its first hit); intersect swaps dropped slots out via S_LAST, S_SWAP,
// S_SWAP2; S_DONE holds on a stall. One item in flight; next taken as m_valid rises.
// Reset (aresetn low, synchronous): active_bits 4096, set full, masks zero,
// live list identity with 64 slots live; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sparse_bitset_engine import sbe_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [BITS_W-1:0] cfg_wr_data,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [2:0]        s_req_type,
    input  wire logic [SLOT_W-1:0] s_word_index,
    input  wire logic [WORD_W-1:0] s_word_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_set_empty,
    output logic [CNT_W-1:0]       m_live_count,
    output logic                   m_hit_found,
    output logic [SLOT_W-1:0]      m_hit_slot
);

    state_t            state_reg, state_next;
    req_t              op_reg, op_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  live_reg, live_next;
    logic              hit_reg, hit_next;
    logic [SLOT_W-1:0] hit_slot_reg, hit_slot_next;
    logic [BITS_W-1:0] active_bits_reg;
    logic              m_valid_reg, m_valid_next;
    logic              m_empty_reg, m_empty_next;
    logic [CNT_W-1:0]  m_live_reg, m_live_next;
    logic              m_hit_reg, m_hit_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;

    store_cmd_t        cmd;
    store_rd_t         rd;
    logic [SLOT_W-1:0] rd_slot, rd_pos;
    logic [WORD_W-1:0] and_word;
    logic [CNT_W-1:0]  pos_m1, live_m1;

    sbe_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .rd_slot (rd_slot),
        .rd_pos  (rd_pos),
        .rd      (rd)
    );

    // Hold the configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_bits_reg <= BITS_W'(4096);
        end else if (cfg_wr_en) begin
            active_bits_reg <= cfg_wr_data;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            live_reg    <= words_in_use(BITS_W'(4096));
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            live_reg    <= live_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        slot_reg     <= slot_next;
        data_reg     <= data_next;
        pos_reg      <= pos_next;
        hit_reg      <= hit_next;
        hit_slot_reg <= hit_slot_next;
        m_empty_reg  <= m_empty_next;
        m_live_reg   <= m_live_next;
        m_hit_reg    <= m_hit_next;
        m_slot_reg   <= m_slot_next;
    end

    assign and_word = rd.set_q & rd.mask_q;
    assign pos_m1   = pos_reg - CNT_W'(1);
    assign live_m1  = live_reg - CNT_W'(1);
    assign s_ready  = (state_reg == S_IDLE);

    // Sequence one item through the store
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        slot_next     = slot_reg;
        data_next     = data_reg;
        pos_next      = pos_reg;
        live_next     = live_reg;
        hit_next      = hit_reg;
        hit_slot_next = hit_slot_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_empty_next  = m_empty_reg;
        m_live_next   = m_live_reg;
        m_hit_next    = m_hit_reg;
        m_slot_next   = m_slot_reg;
        cmd           = '0;
        cmd.wr_slot   = slot_reg;
        rd_slot       = slot_reg;
        rd_pos        = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next       = req_t'(s_req_type);
                    slot_next     = s_word_index;
                    data_next     = s_word_data;
                    hit_next      = 1'b0;
                    hit_slot_next = '0;
                    pos_next      = '0;
                    case (s_req_type) inside
                        REQ_INIT:      state_next = S_INIT;
                        REQ_STAGE:     state_next = S_STAGE;
                        REQ_OR_MASK:   state_next = S_SLOT;
                        REQ_INTERSECT: begin
                            pos_next   = live_reg;
                            state_next = S_ORD;
                        end
                        REQ_CLR_MASK, REQ_INV_MASK, REQ_QUERY: state_next = S_ORD;
                        default:       state_next = S_DONE;
                    endcase
                end
            end
            S_INIT: begin
                cmd.clear  = 1'b1;
                live_next  = words_in_use(active_bits_reg);
                state_next = S_DONE;
            end
            S_STAGE: begin
                cmd.query_we = 1'b1;
                cmd.wdata    = data_reg;
                state_next   = S_DONE;
            end
            // Fetch the next live-list entry, or finish the walk
            S_ORD: begin
                if (op_reg == REQ_INTERSECT) begin
                    if (pos_reg == '0) begin
                        state_next = S_DONE;
                    end else begin
                        pos_next   = pos_m1;
                        rd_pos     = pos_m1[SLOT_W-1:0];
                        state_next = S_SLOT;
                    end
                end else if (pos_reg >= live_reg) begin
                    state_next = S_DONE;
                end else begin
                    rd_pos     = pos_reg[SLOT_W-1:0];
                    state_next = S_SLOT;
                end
            end
            // Read the words of the slot
            S_SLOT: begin
                if (op_reg != REQ_OR_MASK) begin
                    rd_slot   = rd.order_q;
                    slot_next = rd.order_q;
                end
                state_next = S_EXEC;
            end
            // Modify and write back
            S_EXEC: begin
                case (op_reg)
                    REQ_OR_MASK: begin
                        cmd.mask_we = 1'b1;
                        cmd.wdata   = rd.mask_q | data_reg;
                        state_next  = S_DONE;
                    end
                    REQ_CLR_MASK: begin
                        cmd.mask_we = 1'b1;
                        cmd.wdata   = '0;
                        pos_next    = pos_reg + CNT_W'(1);
                        state_next  = S_ORD;
                    end
                    REQ_INV_MASK: begin
                        cmd.mask_we = 1'b1;
                        cmd.wdata   = ~rd.mask_q;
                        pos_next    = pos_reg + CNT_W'(1);
                        state_next  = S_ORD;
                    end
                    REQ_QUERY: begin
                        if ((rd.set_q & rd.query_q) != '0) begin
                            hit_next      = 1'b1;
                            hit_slot_next = slot_reg;
                            state_next    = S_DONE;
                        end else begin
                            pos_next   = pos_reg + CNT_W'(1);
                            state_next = S_ORD;
                        end
                    end
                    REQ_INTERSECT: begin
                        if (and_word != rd.set_q) begin
                            cmd.set_we = 1'b1;
                            cmd.wdata  = and_word;
                        end
                        state_next = (and_word == '0) ? S_LAST : S_ORD;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            // Swap a zeroed slot with the last live entry
            S_LAST: begin
                rd_pos     = live_m1[SLOT_W-1:0];
                state_next = S_SWAP;
            end
            S_SWAP: begin
                cmd.order_we    = 1'b1;
                cmd.order_wpos  = pos_reg[SLOT_W-1:0];
                cmd.order_wdata = rd.order_q;
                state_next      = S_SWAP2;
            end
            S_SWAP2: begin
                cmd.order_we    = 1'b1;
                cmd.order_wpos  = live_m1[SLOT_W-1:0];
                cmd.order_wdata = slot_reg;
                live_next       = live_m1;
                state_next      = S_ORD;
            end
            // Hand the result to the output register once it is free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_empty_next = (live_reg == '0);
                    m_live_next  = live_reg;
                    m_hit_next   = hit_reg;
                    m_slot_next  = hit_slot_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_set_empty  = m_empty_reg;
    assign m_live_count = m_live_reg;
    assign m_hit_found  = m_hit_reg;
    assign m_hit_slot   = m_slot_reg;

endmodule

`default_nettype wire

// File: rtl/sbe_checker.sv
// Port-level checks for the sparse bitset engine, bound to the top level.
// Depends on sbe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbe_checker import sbe_pkg::*; (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic              m_set_empty,
    input wire logic [CNT_W-1:0]  m_live_count,
    input wire logic              m_hit_found,
    input wire logic [SLOT_W-1:0] m_hit_slot
);

    // Empty flag agrees with the live count
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_set_empty == (m_live_count == '0)))
        else $error("set_empty disagrees with live_count");

    // Live count never exceeds the store depth
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_live_count <= CNT_W'(MAX_WORDS)))
        else $error("live_count beyond store depth");

    // A miss reports slot zero; a hit needs a live slot
    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit_found |-> (m_hit_slot == '0))
        else $error("hit_slot nonzero without hit");

    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit_found |-> (m_live_count != '0))
        else $error("hit reported on empty set");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_live_count) && $stable(m_hit_slot))
        else $error("result changed while stalled");

endmodule

bind sparse_bitset_engine sbe_checker u_sbe_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_set_empty  (m_set_empty),
    .m_live_count (m_live_count),
    .m_hit_found  (m_hit_found),
    .m_hit_slot   (m_hit_slot)
);

`default_nettype wire

// File: bench/sparse_bitset_engine_tb.sv
// Self-checking bench for sparse_bitset_engine: random and directed items,
// a predictor of the word store and live list, updated per accepted item. Depends on sbe_pkg.
`timescale 1ns / 1ps

module sparse_bitset_engine_tb;
    import sbe_pkg::*;

    localparam logic [2:0] REQ_UNKNOWN = 3'd7;
    localparam int IDLE_PCT = 29;

    typedef struct packed {
        logic [2:0]        req;
        logic [SLOT_W-1:0] idx;
        logic [WORD_W-1:0] data;
    } item_t;

    typedef struct packed {
        logic              empty;
        logic [CNT_W-1:0]  count;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } status_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [BITS_W-1:0] cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_req_type = '0;
    logic [SLOT_W-1:0] s_word_index = '0;
    logic [WORD_W-1:0] s_word_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_set_empty;
    logic [CNT_W-1:0]  m_live_count;
    logic              m_hit_found;
    logic [SLOT_W-1:0] m_hit_slot;

    // Predictor state
    logic [WORD_W-1:0] words_m [MAX_WORDS];
    logic [WORD_W-1:0] masks_m [MAX_WORDS];
    logic [WORD_W-1:0] probes_m [MAX_WORDS];
    int                order_m [MAX_WORDS];
    int                live_m;
    int                bits_m;

    item_t   pending_items[$];
    status_t expected_status[$];
    int      mismatches = 0;
    int      accepted = 0;
    int      checked = 0;
    int      hits_seen = 0;
    int      drops_seen = 0;

    sparse_bitset_engine u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_word_index (s_word_index),
        .s_word_data  (s_word_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_set_empty  (m_set_empty),
        .m_live_count (m_live_count),
        .m_hit_found  (m_hit_found),
        .m_hit_slot   (m_hit_slot)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Words in use for the current bit count, saturated at the store depth
    function automatic int word_span();
        int n;
        n = (bits_m + 63) / 64;
        return (n > MAX_WORDS) ? MAX_WORDS : n;
    endfunction

    function automatic void rebuild_set();
        for (int i = 0; i < MAX_WORDS; i++) begin
            words_m[i] = '1;
            masks_m[i] = '0;
            order_m[i] = i;
        end
        live_m = word_span();
    endfunction

    // Apply one request to the predictor and return its status
    function automatic status_t apply_request(item_t it);
        status_t r;
        int i;
        int slot;
        int last;
        logic [WORD_W-1:0] w;
        r = '0;
        case (it.req)
            REQ_INIT: rebuild_set();
            REQ_CLR_MASK: for (i = 0; i < live_m; i++) masks_m[order_m[i]] = '0;
            REQ_INV_MASK: for (i = 0; i < live_m; i++) masks_m[order_m[i]] = ~masks_m[order_m[i]];
            REQ_OR_MASK: masks_m[it.idx] = masks_m[it.idx] | it.data;
            REQ_STAGE: probes_m[it.idx] = it.data;
            REQ_INTERSECT: begin
                i = live_m;
                while (i > 0) begin
                    i--;
                    slot = order_m[i];
                    w = words_m[slot] & masks_m[slot];
                    words_m[slot] = w;
                    if (w == '0) begin
                        last = live_m - 1;
                        order_m[i] = order_m[last];
                        order_m[last] = slot;
                        live_m = last;
                        drops_seen++;
                    end
                end
            end
            REQ_QUERY: begin
                for (i = 0; i < live_m; i++) begin
                    slot = order_m[i];
                    if ((words_m[slot] & probes_m[slot]) != '0) begin
                        r.hit = 1'b1;
                        r.slot = slot[SLOT_W-1:0];
                        hits_seen++;
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.empty = (live_m == 0);
        r.count = live_m[CNT_W-1:0];
        return r;
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("%0t mismatch %s: got %0d want %0d", $realtime, field, got, want);
        mismatches++;
    endtask

    // Long stretch with no idling on either side
    function automatic int quiet();
        return (accepted >= 900 && accepted < 1150) ? 1 : 0;
    endfunction

    // Driver: predict on accept, then load the next item or idle
    always @(posedge aclk) begin
        item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.req = s_req_type;
                it.idx = s_word_index;
                it.data = s_word_data;
                expected_status.insert(expected_status.size(), apply_request(it));
                accepted++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && !(quiet() == 0 &&
                        $urandom_range(99) < IDLE_PCT)) begin
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= it.req;
                    s_word_index <= it.idx;
                    s_word_data <= it.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result item with the oldest status
    always @(posedge aclk) begin
        status_t e;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_status.size() == 0) begin
                    report("unexpected result", 0, 0);
                end else begin
                    e = expected_status.pop_front();
                    checked++;
                    if (m_set_empty !== e.empty) report("set_empty", m_set_empty, e.empty);
                    if (m_live_count !== e.count) report("live_count", m_live_count, e.count);
                    if (m_hit_found !== e.hit) report("hit_found", m_hit_found, e.hit);
                    if (m_hit_slot !== e.slot) report("hit_slot", m_hit_slot, e.slot);
                end
            end
            m_ready <= (quiet() == 1) || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic push_item(logic [2:0] rq, int idx, logic [WORD_W-1:0] d);
        item_t it;
        it.req = rq;
        it.idx = idx[SLOT_W-1:0];
        it.data = d;
        pending_items.insert(pending_items.size(), it);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            3: return {$urandom, $urandom} & {$urandom, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_status.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_bits(int v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v[BITS_W-1:0];
        bits_m = v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Well-formed round: build a mask, intersect, probe; sometimes reinit first
    task automatic push_round(ref int n);
        int span;
        int k;
        span = word_span();
        if ($urandom_range(3) == 0) begin
            push_item(REQ_INIT, $urandom_range(63), rand_word());
            n++;
        end
        push_item($urandom_range(1) ? REQ_CLR_MASK : REQ_INV_MASK, $urandom_range(63),
                  rand_word());
        n++;
        k = $urandom_range(1, 8);
        repeat (k) begin
            push_item(REQ_OR_MASK, (span > 0 && $urandom_range(4) != 0) ?
                      $urandom_range(span - 1) : $urandom_range(63), rand_word());
            n++;
        end
        push_item(REQ_INTERSECT, $urandom_range(63), rand_word());
        n++;
        repeat ($urandom_range(2)) begin
            push_item(REQ_STAGE, $urandom_range(63), rand_word());
            n++;
        end
        push_item(REQ_QUERY, $urandom_range(63), rand_word());
        n++;
    endtask

    initial begin
        int settings [9];
        int n;
        settings = '{4096, 0, 1, 64, 65, 8191, 4097, 63, 700};
        bits_m = 4096;
        for (int i = 0; i < MAX_WORDS; i++) probes_m[i] = '0;
        rebuild_set();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Preload every query word so no query reads an unwritten one
        for (int i = 0; i < MAX_WORDS; i++) push_item(REQ_STAGE, i, rand_word());

        // Directed: field extremes, every request, unknown request
        push_item(REQ_QUERY, 0, '0);
        push_item(REQ_OR_MASK, 0, '1);
        push_item(REQ_OR_MASK, 63, 64'h8000_0000_0000_0001);
        push_item(REQ_INTERSECT, 0, '0);
        push_item(REQ_QUERY, 63, '1);
        push_item(REQ_STAGE, 0, '0);
        push_item(REQ_STAGE, 63, '1);
        push_item(REQ_QUERY, 0, '0);
        push_item(REQ_INV_MASK, 0, '0);
        push_item(REQ_INTERSECT, 0, '0);
        push_item(REQ_UNKNOWN, 63, '1);
        push_item(REQ_CLR_MASK, 0, '0);
        push_item(REQ_INTERSECT, 0, '0);
        push_item(REQ_QUERY, 0, '0);
        push_item(REQ_UNKNOWN, 0, '0);
        push_item(REQ_INIT, 0, '0);
        push_item(REQ_INV_MASK, 0, '0);
        push_item(REQ_INTERSECT, 0, '0);
        push_item(REQ_QUERY, 0, '0);

        // Phases of random items, each under its own bit count
        for (int p = 0; p < 10; p++) begin
            wait_drained();
            repeat (20) @(posedge aclk);
            if (p < 9) write_bits(settings[p]);
            else write_bits($urandom_range(8191));
            push_item(REQ_INIT, 0, '0);
            n = 0;
            while (n < 180) begin
                if ($urandom_range(99) < 80) begin
                    push_round(n);
                end else begin
                    push_item(3'($urandom_range(7)), $urandom_range(63), rand_word());
                    n++;
                end
            end
        end

        wait_drained();
        repeat (50) @(posedge aclk);
        $display("Covered %0d items and %0d results over 10 bit counts;", accepted, checked);
        $display("%0d query hits, %0d slot drops.", hits_seen, drops_seen);
        if (mismatches == 0 && expected_status.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
